FILE: src/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, table constants and lookup functions of the roman numeral
// encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned NumberW  = 12;
  localparam int unsigned SymbolW  = 7;
  localparam int unsigned StepCnt  = 13;
  localparam int unsigned StepIdxW = 4;

  localparam logic [SymbolW-1:0] SymNone = 7'h00;
  localparam logic [SymbolW-1:0] SymM    = 7'h4d;
  localparam logic [SymbolW-1:0] SymD    = 7'h44;
  localparam logic [SymbolW-1:0] SymC    = 7'h43;
  localparam logic [SymbolW-1:0] SymL    = 7'h4c;
  localparam logic [SymbolW-1:0] SymX    = 7'h58;
  localparam logic [SymbolW-1:0] SymV    = 7'h56;
  localparam logic [SymbolW-1:0] SymI    = 7'h49;

  // one greedy step handed from the front to the back
  typedef struct packed {
    logic [StepIdxW-1:0] idx;
    logic                last;
    logic                empty;
  } token_t;

  typedef enum logic {
    FrontIdle,
    FrontBusy
  } front_state_e;

  function automatic logic [NumberW-1:0] step_value(input logic [StepIdxW-1:0] idx);
    logic [NumberW-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [SymbolW-1:0] first_letter(input logic [StepIdxW-1:0] idx);
    logic [SymbolW-1:0] s;
    case (idx)
      4'd0:    s = SymM;
      4'd1:    s = SymC;
      4'd2:    s = SymD;
      4'd3:    s = SymC;
      4'd4:    s = SymC;
      4'd5:    s = SymX;
      4'd6:    s = SymL;
      4'd7:    s = SymX;
      4'd8:    s = SymX;
      4'd9:    s = SymI;
      4'd10:   s = SymV;
      4'd11:   s = SymI;
      4'd12:   s = SymI;
      default: s = SymNone;
    endcase
    return s;
  endfunction

  // none for single-letter steps
  function automatic logic [SymbolW-1:0] second_letter(input logic [StepIdxW-1:0] idx);
    logic [SymbolW-1:0] s;
    case (idx)
      4'd1:    s = SymM;
      4'd3:    s = SymD;
      4'd5:    s = SymC;
      4'd7:    s = SymL;
      4'd9:    s = SymX;
      4'd11:   s = SymV;
      default: s = SymNone;
    endcase
    return s;
  endfunction

endpackage

FILE: src/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Takes a number, walks the greedy table: one token per cycle unless full_i.
// ----------------------------------------------------------------------------
module rne_front
  import rne_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NumberW-1:0] number_i,
  input  logic               full_i,
  output logic               push_o,
  output token_t             token_o
);

  front_state_e       state_q, state_d;
  logic [NumberW-1:0] rest_q, rest_d;
  logic [StepIdxW-1:0] idx;
  logic [NumberW-1:0] diff;
  logic                zero;

  // first table entry not above the remainder; remainders only shrink,
  // so this is always at or past the previous step
  always_comb begin
    idx = StepIdxW'(StepCnt - 1);
    for (int i = StepCnt - 1; i >= 0; i--) begin
      if (rest_q >= step_value(StepIdxW'(i))) begin
        idx = StepIdxW'(i);
      end
    end
  end

  assign diff = rest_q - step_value(idx);
  assign zero = (rest_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FrontIdle: begin
        if (in_valid_i) state_d = FrontBusy;
      end
      FrontBusy: begin
        if (!full_i && (zero || diff == '0)) state_d = FrontIdle;
      end
      default: state_d = FrontIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    rest_d      = rest_q;
    token_o.idx   = zero ? '0 : idx;
    token_o.empty = zero;
    token_o.last  = zero || (diff == '0);
    case (state_q)
      FrontIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) rest_d = number_i;
      end
      FrontBusy: begin
        push_o = !full_i;
        if (!full_i) rest_d = diff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrontIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
  end

endmodule

FILE: src/rne_fifo.sv
// ----------------------------------------------------------------------------
// rne_fifo
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
module rne_fifo
  import rne_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output token_t data_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("token queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> (cnt_q == CntW'(Depth)))
    else $error("token queue lost an entry while full");

endmodule

FILE: src/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Expands step tokens into letters and holds the output beat.
// ----------------------------------------------------------------------------
module rne_back
  import rne_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  token_t             token_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SymbolW-1:0] symbol_o,
  output logic               last_o,
  output logic               empty_o
);

  logic               valid_q, valid_d;
  logic               pend_q, pend_d;
  logic [SymbolW-1:0] sym_q, sym_d;
  logic               last_q, last_d;
  logic               emp_q, emp_d;
  logic [SymbolW-1:0] sec_sym_q, sec_sym_d;
  logic               sec_last_q, sec_last_d;
  logic               load;
  logic [SymbolW-1:0] sec;

  assign load = !valid_q || out_ready_i;
  assign sec  = second_letter(token_i.idx);

  always_comb begin
    valid_d    = valid_q;
    pend_d     = pend_q;
    sym_d      = sym_q;
    last_d     = last_q;
    emp_d      = emp_q;
    sec_sym_d  = sec_sym_q;
    sec_last_d = sec_last_q;
    pop_o      = 1'b0;
    if (load && pend_q) begin
      valid_d = 1'b1;
      pend_d  = 1'b0;
      sym_d   = sec_sym_q;
      last_d  = sec_last_q;
      emp_d   = 1'b0;
    end else if (load && !empty_i) begin
      pop_o   = 1'b1;
      valid_d = 1'b1;
      emp_d   = token_i.empty;
      sym_d   = token_i.empty ? SymNone : first_letter(token_i.idx);
      // two-letter step: hold the second letter back for the next beat
      if (!token_i.empty && sec != SymNone) begin
        pend_d     = 1'b1;
        last_d     = 1'b0;
        sec_sym_d  = sec;
        sec_last_d = token_i.last;
      end else begin
        last_d = token_i.last;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    last_q     <= last_d;
    emp_q      <= emp_d;
    sec_sym_q  <= sec_sym_d;
    sec_last_q <= sec_last_d;
  end

  assign out_valid_o = valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;
  assign empty_o     = emp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && emp_q) |-> (last_q && sym_q == SymNone))
    else $error("empty beat must be a lone last beat with no letter");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !emp_q) |-> (sym_q != SymNone))
    else $error("letter beat carries no letter");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> (valid_q && !last_q))
    else $error("second letter pending behind a missing or last beat");

endmodule

FILE: src/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit unsigned number into roman numeral letters, one ASCII
// letter per output beat, most significant first.
// ----------------------------------------------------------------------------
// Each input beat carries a number from 0 to 4095; the block answers with one
// beat per letter, tlast on the final one. Zero gives a single beat with
// symbol 0, tuser high and tlast high. Numbers of 4000 and up give more than
// three M letters. The front accepts a number and then resolves one greedy
// table step per cycle while the token queue has room (one compare bank and
// one subtract) into that queue, a two-letter step such as CM being a single
// token; the back sends one letter per cycle while the output is ready. The
// first letter beat is offered once the number has passed the front's
// remainder register, the token queue and the back's output register. A new
// number is accepted in the cycle after the front has queued the last step of
// the previous one, while the back is still sending its letters.
// ----------------------------------------------------------------------------
module roman_numeral_encoder
  import rne_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] number_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] symbol
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] empty_result
);

  logic               push, pop, full, q_empty;
  token_t             push_tok, pop_tok;
  logic [SymbolW-1:0] symbol;

  rne_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .number_i   (s_axis_tdata_i[NumberW-1:0]),
    .full_i     (full),
    .push_o     (push),
    .token_o    (push_tok)
  );

  rne_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_tok),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_tok),
    .empty_o (q_empty)
  );

  rne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .token_i     (pop_tok),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .symbol_o    (symbol),
    .last_o      (m_axis_tlast_o),
    .empty_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, symbol};

endmodule

FILE: test/tb_roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// tb_roman_numeral_encoder
// Self-checking bench for the roman numeral encoder: numbers are streamed in,
// every letter beat that comes out is checked against a greedy conversion
// done in the bench, with random gaps and backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_roman_numeral_encoder
  import rne_pkg::*;
;

  localparam int unsigned MaxLetters = 15;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned RandCount  = 147;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
    logic               empty;
  } letter_t;

  typedef struct packed {
    logic [NumberW-1:0] value;
    logic [SymbolW-1:0] lead;
    logic [SymbolW-1:0] trail;
  } step_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [15:0] s_data   = '0;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;
  logic        m_user;

  logic [15:0] number_q[$];
  letter_t     numeral_q[$];
  int          sent_cnt   = 0;
  int          errors     = 0;
  int          quiet_cnt  = 0;
  letter_t     want_l;
  logic        calm;

  roman_numeral_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // no random gaps on either side while this window of numbers goes in
  assign calm = (sent_cnt >= 70) && (sent_cnt < 110);

  function automatic step_t roman_step(input int idx);
    step_t st;
    case (idx)
      0:       st = '{12'd1000, SymM, SymNone};
      1:       st = '{12'd900,  SymC, SymM};
      2:       st = '{12'd500,  SymD, SymNone};
      3:       st = '{12'd400,  SymC, SymD};
      4:       st = '{12'd100,  SymC, SymNone};
      5:       st = '{12'd90,   SymX, SymC};
      6:       st = '{12'd50,   SymL, SymNone};
      7:       st = '{12'd40,   SymX, SymL};
      8:       st = '{12'd10,   SymX, SymNone};
      9:       st = '{12'd9,    SymI, SymX};
      10:      st = '{12'd5,    SymV, SymNone};
      11:      st = '{12'd4,    SymI, SymV};
      default: st = '{12'd1,    SymI, SymNone};
    endcase
    return st;
  endfunction

  // greedy conversion of one accepted number into its expected letter beats
  function automatic void queue_numeral(input logic [15:0] word);
    int unsigned rest;
    int          count;
    step_t       st;
    letter_t     letters[MaxLetters];
    rest  = word[NumberW-1:0];
    count = 0;
    if (rest == 0) begin
      numeral_q.push_back('{SymNone, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < StepCnt; i++) begin
      st = roman_step(i);
      while (rest >= st.value && count < MaxLetters) begin
        letters[count] = '{st.lead, 1'b0, 1'b0};
        count++;
        if (st.trail != SymNone && count < MaxLetters) begin
          letters[count] = '{st.trail, 1'b0, 1'b0};
          count++;
        end
        rest -= st.value;
      end
    end
    letters[count-1].last = 1'b1;
    for (int i = 0; i < count; i++) numeral_q.push_back(letters[i]);
  endfunction

  function automatic logic [15:0] random_number();
    logic [15:0] word;
    word = '0;
    case ($urandom_range(9))
      0:       word[NumberW-1:0] = NumberW'($urandom_range(20, 1));
      1:       word[NumberW-1:0] = '0;
      2:       word[NumberW-1:0] = NumberW'($urandom_range(4095, 3000));
      3:       word[NumberW-1:0] = NumberW'($urandom_range(3999, 3800));
      default: word[NumberW-1:0] = NumberW'($urandom_range(4095));
    endcase
    // upper tdata bits must be ignored by the block
    if ($urandom_range(7) == 0) word[15:12] = 4'($urandom_range(15));
    return word;
  endfunction

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        queue_numeral(s_data);
      end
      if (!s_valid || s_ready) begin
        if (number_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          s_valid  <= 1'b1;
          s_data   <= number_q.pop_front();
          sent_cnt <= sent_cnt + 1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (numeral_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual symbol %h last %b empty %b",
                 $time, m_data[SymbolW-1:0], m_last, m_user);
        errors++;
      end else begin
        want_l = numeral_q.pop_front();
        if (m_data[SymbolW-1:0] !== want_l.symbol) begin
          $display("%0t: symbol mismatch, expected %h actual %h",
                   $time, want_l.symbol, m_data[SymbolW-1:0]);
          errors++;
        end
        if (m_last !== want_l.last) begin
          $display("%0t: tlast mismatch, expected %b actual %b", $time, want_l.last, m_last);
          errors++;
        end
        if (m_user !== want_l.empty) begin
          $display("%0t: empty flag mismatch, expected %b actual %b",
                   $time, want_l.empty, m_user);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, QuietLimit);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    // extremes, every table step alone, the longest numeral and stray upper bits
    number_q.push_back(16'd0);
    number_q.push_back(16'd1);
    number_q.push_back(16'd4);
    number_q.push_back(16'd5);
    number_q.push_back(16'd9);
    number_q.push_back(16'd10);
    number_q.push_back(16'd40);
    number_q.push_back(16'd50);
    number_q.push_back(16'd90);
    number_q.push_back(16'd100);
    number_q.push_back(16'd400);
    number_q.push_back(16'd500);
    number_q.push_back(16'd900);
    number_q.push_back(16'd1000);
    number_q.push_back(16'd1994);
    number_q.push_back(16'd2048);
    number_q.push_back(16'd3888);
    number_q.push_back(16'd3999);
    number_q.push_back(16'd4000);
    number_q.push_back(16'd4095);
    number_q.push_back(16'hf000);
    number_q.push_back(16'ha7b3);
    number_q.push_back(16'h5f0f);
    for (int i = 0; i < RandCount; i++) number_q.push_back(random_number());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (number_q.size() != 0 || s_valid || numeral_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rne_pkg.sv
src/rne_front.sv
src/rne_fifo.sv
src/rne_back.sv
src/roman_numeral_encoder.sv
test/tb_roman_numeral_encoder.sv
